// File: hdl/oahs_pkg.sv
package oahs_pkg;

   // default number of slots in the table
   localparam int TABLE_SIZE_DEF = 1024;

   localparam int KEY_W   = 32;
   localparam int OP_W    = 2;
   localparam int COUNT_W = 11;
   localparam int STAT_W  = 2;

   // request operations
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   // slot status codes
   localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd0;
   localparam logic [STAT_W-1:0] ST_USED    = 2'd1;
   localparam logic [STAT_W-1:0] ST_DELETED = 2'd2;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [KEY_W-1:0]  key;
   } slot_type;

endpackage

// File: hdl/open_addressing_hash_set.sv
// open-addressing hash set of signed 32-bit keys with tombstones. each request on the req_ stream
// carries an operation (insert, delete, lookup) and a key and gets exactly one response on the
// rsp_ stream with a success flag and the number of keys held after the request. for a key k the
// home slot is h = |k| mod TABLE_SIZE and probe i visits (h + i*(1 + h)) mod TABLE_SIZE, for at
// most TABLE_SIZE probes. slot key and status live together in one single-port-read,
// single-port-write synchronous memory, so the walk examines one slot while it reads the next;
// a non-power-of-two TABLE_SIZE adds a reciprocal multiplication and a remainder correction
// that form h. one request is in flight at a time; a finished response waits in an output
// register, so the next request is taken while it is still pending. after reset the memory is
// swept to empty, one slot per cycle, while req_tready stays low. an operation code of 3
// changes nothing and answers success 0.
module open_addressing_hash_set_core
   import oahs_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,    // [1:0] op, [33:2] key, [39:34] zero
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata     // [0] success, [11:1] count, [15:12] zero
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam logic [AW:0]   M_W    = (AW+1)'(TABLE_SIZE);
   localparam logic [AW-1:0] M_LAST = AW'(TABLE_SIZE - 1);
   localparam bit POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
   // floor(2^32 / TABLE_SIZE), the quotient estimate is at most one too small
   localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << 32) / TABLE_SIZE);
   localparam logic [KEY_W-1:0] M_K   = KEY_W'(TABLE_SIZE);

   // control states
   localparam logic [2:0] S_CLEAR = 3'd0;  // sweep the memory to empty
   localparam logic [2:0] S_IDLE  = 3'd1;  // wait for a request
   localparam logic [2:0] S_HASH  = 3'd2;  // remainder and correction
   localparam logic [2:0] S_ISSUE = 3'd3;  // read the home slot
   localparam logic [2:0] S_CHECK = 3'd4;  // examine a slot, read the next
   localparam logic [2:0] S_MUL   = 3'd5;  // reciprocal multiply

   // slot memory
   slot_type mem [TABLE_SIZE];
   slot_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   slot_type      mem_wdata;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [KEY_W-1:0]   mag_ff, mag_in;
   logic [2*KEY_W-1:0] prod_ff, prod_in;
   logic [AW-1:0]      slot_ff, slot_in;
   logic [AW-1:0]      step_ff, step_in;
   logic [AW-1:0]      probe_ff, probe_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_success_ff, rsp_success_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // combinational helpers
   logic [KEY_W-1:0]   req_key;
   logic [KEY_W-1:0]   req_mag;
   logic [KEY_W-1:0]   quot_est;
   logic [KEY_W-1:0]   rem_raw;
   logic [KEY_W-1:0]   rem_fix;
   logic [AW-1:0]      rem_new;
   logic [AW:0]        slot_sum;
   logic [AW-1:0]      next_slot;
   logic               is_match;
   logic               out_free;
   logic               stop;
   logic               ok;
   logic               do_write;
   logic [STAT_W-1:0]  new_status;
   logic [COUNT_W-1:0] new_count;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_count_ff, rsp_success_ff};

   assign req_key = req_tdata[33:2];
   // the most negative key wraps to 2^31, which is its true magnitude as unsigned
   assign req_mag = req_key[KEY_W-1] ? (KEY_W'(0) - req_key) : req_key;

   // remainder from the registered product, lands in [0, 2*TABLE_SIZE) before correction
   assign quot_est = prod_ff[2*KEY_W-1:KEY_W];
   assign rem_raw  = mag_ff - KEY_W'(quot_est * M_K);
   assign rem_fix  = (rem_raw >= M_K) ? (rem_raw - M_K) : rem_raw;
   assign rem_new  = rem_fix[AW-1:0];

   // both addends stay below TABLE_SIZE, so one compare and subtract wraps the sum
   assign slot_sum  = {1'b0, slot_ff} + {1'b0, step_ff};
   assign next_slot = (slot_sum >= M_W) ? AW'(slot_sum - M_W) : slot_sum[AW-1:0];

   assign is_match = (rd_data_ff.status == ST_USED) && (rd_data_ff.key == key_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // probe decision for the slot in rd_data_ff
   always_comb begin
      stop       = 1'b0;
      ok         = 1'b0;
      do_write   = 1'b0;
      new_status = ST_USED;
      new_count  = count_ff;
      if (op_ff != OP_INSERT && op_ff != OP_DELETE && op_ff != OP_LOOKUP) begin
         stop = 1'b1;
      end else if (is_match) begin
         stop = 1'b1;
         ok   = (op_ff != OP_INSERT);
         if (op_ff == OP_DELETE) begin
            do_write   = 1'b1;
            new_status = ST_DELETED;
            new_count  = count_ff - 1'b1;
         end
      end else if (op_ff == OP_INSERT && rd_data_ff.status != ST_USED) begin
         // first empty or deleted slot takes the key
         stop      = 1'b1;
         ok        = 1'b1;
         do_write  = 1'b1;
         new_count = count_ff + 1'b1;
      end else if (op_ff != OP_INSERT && rd_data_ff.status == ST_EMPTY) begin
         stop = 1'b1;
      end else if (probe_ff == M_LAST) begin
         // probe sequence exhausted
         stop = 1'b1;
      end
   end

   // next-state logic
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      mag_in         = mag_ff;
      prod_in        = prod_ff;
      slot_in        = slot_ff;
      step_in        = step_ff;
      probe_in       = probe_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_success_in = rsp_success_ff;
      rsp_count_in   = rsp_count_ff;
      rd_addr        = slot_ff;
      mem_we         = 1'b0;
      mem_waddr      = slot_ff;
      mem_wdata      = '{status: new_status, key: key_ff};

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '{status: ST_EMPTY, key: '0};
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == M_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[1:0];
               key_in   = req_key;
               mag_in   = req_mag;
               probe_in = '0;
               if (POW2) begin
                  slot_in  = req_mag[AW-1:0];
                  step_in  = (req_mag[AW-1:0] == M_LAST) ? '0 : req_mag[AW-1:0] + 1'b1;
                  state_in = S_ISSUE;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            prod_in  = mag_ff * RECIP;
            state_in = S_HASH;
         end
         S_HASH: begin
            slot_in  = rem_new;
            step_in  = (rem_new == M_LAST) ? '0 : rem_new + 1'b1;
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            rd_addr  = slot_ff;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stop) begin
               // hold on the same slot until the output register is free
               rd_addr = slot_ff;
               if (out_free) begin
                  mem_we         = do_write;
                  count_in       = new_count;
                  rsp_valid_in   = 1'b1;
                  rsp_success_in = ok;
                  rsp_count_in   = new_count;
                  state_in       = S_IDLE;
               end
            end else begin
               rd_addr  = next_slot;
               slot_in  = next_slot;
               probe_in = probe_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      mag_ff         <= mag_in;
      prod_ff        <= prod_in;
      slot_ff        <= slot_in;
      step_ff        <= step_in;
      probe_ff       <= probe_in;
      rsp_success_ff <= rsp_success_in;
      rsp_count_ff   <= rsp_count_in;
   end

endmodule

// File: dv/hash_set_checker.sv
// watches both streams, keeps its own copy of the table and compares every response
module hash_set_checker
   import oahs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,    // [1:0] op, [33:2] key, [39:34] zero
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,    // [0] success, [11:1] count, [15:12] zero
   output int          fail_count,
   output int          replies_owed
);

   localparam int SLOT_W = $clog2(TABLE_SIZE_DEF);

   typedef struct packed {
      logic               success;
      logic [COUNT_W-1:0] count;
   } reply_type;

   logic [KEY_W-1:0]   model_key    [TABLE_SIZE_DEF];
   logic [STAT_W-1:0]  model_status [TABLE_SIZE_DEF];
   logic [COUNT_W-1:0] model_count;
   reply_type          pending_replies [$];

   // walk the probe sequence of one request and update the table copy
   task automatic walk_table(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                             output logic hit);
      logic [KEY_W-1:0]  mag;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] stride;
      logic              done;
      int                probe;
      hit  = 1'b0;
      done = !(op == OP_INSERT || op == OP_DELETE || op == OP_LOOKUP);
      // the most negative key wraps to 2^31 as an unsigned magnitude
      mag    = key[KEY_W-1] ? (32'd0 - key) : key;
      slot   = mag[SLOT_W-1:0];
      stride = slot + 1'b1;
      for (probe = 0; probe < TABLE_SIZE_DEF && !done; probe++) begin
         if (model_status[slot] == ST_USED && model_key[slot] == key) begin
            hit = (op != OP_INSERT);
            if (op == OP_DELETE) begin
               model_status[slot] = ST_DELETED;
               model_count        = model_count - 1'b1;
            end
            done = 1'b1;
         end else if (op == OP_INSERT) begin
            if (model_status[slot] != ST_USED) begin
               model_key[slot]    = key;
               model_status[slot] = ST_USED;
               model_count        = model_count + 1'b1;
               hit                = 1'b1;
               done               = 1'b1;
            end
         end else if (model_status[slot] == ST_EMPTY) begin
            done = 1'b1;
         end
         if (!done) slot = slot + stride;
      end
   endtask

   always @(posedge clock) begin : monitor
      reply_type want;
      reply_type got;
      logic      hit;
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE_DEF; i++) model_status[i] = ST_EMPTY;
         model_count = '0;
         pending_replies.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            walk_table(req_tdata[1:0], req_tdata[33:2], hit);
            want.success = hit;
            want.count   = model_count;
            pending_replies.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.success = rsp_tdata[0];
            got.count   = rsp_tdata[11:1];
            if (pending_replies.size() == 0) begin
               $error("response with no request waiting: success %0d count %0d",
                      got.success, got.count);
               fail_count++;
            end else begin
               want = pending_replies.pop_front();
               if (got.success !== want.success) begin
                  $error("success mismatch: expected %0d, actual %0d",
                         want.success, got.success);
                  fail_count++;
               end
               if (got.count !== want.count) begin
                  $error("count mismatch: expected %0d, actual %0d", want.count, got.count);
                  fail_count++;
               end
            end
         end
      end
      replies_owed = pending_replies.size();
   end

endmodule

// File: dv/open_addressing_hash_set_core_tb.sv
// stimulus and verdict for the hash set core; the checker beside the dut does all prediction
module open_addressing_hash_set_core_tb
   import oahs_pkg::*;
();

   // op code with no meaning, must leave the table alone
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // cycles without any transfer before the run is declared hung; the slowest gap is the
   // clearing sweep after reset or a full-length walk plus the long receiver hold
   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int RANDOM_PER_PHASE = 300;
   localparam int LONG_HOLD        = 400;
   localparam int TAIL_CYCLES      = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;     // [1:0] op, [33:2] key, [39:34] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [0] success, [11:1] count, [15:12] zero

   int fail_count;
   int replies_owed;

   // idle percentages of the two sides, changed per phase
   int tx_idle_pct = 31;
   int rx_idle_pct = 46;
   int phase       = 0;

   // receiver hold bookkeeping
   int   hold_left = 0;
   logic hold_done = 1'b0;

   int quiet_cycles = 0;

   always #1 clock = ~clock;

   open_addressing_hash_set_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hash_set_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .replies_owed (replies_owed)
   );

   // receiver: random back-pressure, plus one long hold when the second phase begins so the
   // output register fills, the walk finishes and req_tready has to drop
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (phase == 1 && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= LONG_HOLD;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // watchdog: any transfer on either stream restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("open_addressing_hash_set_core test failed");
            $finish;
         end
      end
   end

   // offer one request and return at the edge where it transfers; valid is only lowered
   // for a random gap, so back-to-back requests keep it high without a second assignment
   task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, key, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering and wait for every outstanding response
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
   endtask

   initial begin
      logic [KEY_W-1:0]  recent_keys [16];
      logic [KEY_W-1:0]  key;
      logic [OP_W-1:0]   op;
      logic [KEY_W-1:0]  home;
      int                pick;
      for (int i = 0; i < 16; i++) recent_keys[i] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part, on the first phase's idling
      send_request(OP_LOOKUP, 32'd0);            // lookup in an empty table
      send_request(OP_INSERT, 32'd0);
      send_request(OP_INSERT, 32'd0);            // duplicate insert fails
      send_request(OP_INSERT, 32'h8000_0000);    // most negative key, collides with 0
      send_request(OP_LOOKUP, 32'h8000_0000);
      send_request(OP_INSERT, 32'h7FFF_FFFF);    // home 1023, stride wraps to zero
      send_request(OP_INSERT, 32'd1023);         // same single-slot orbit: probes run out
      send_request(OP_LOOKUP, 32'd1023);         // probes run out on lookup too
      send_request(OP_DELETE, 32'd0);            // leaves a tombstone at slot 0
      send_request(OP_LOOKUP, 32'h8000_0000);    // walks past the tombstone
      send_request(OP_INSERT, 32'd1024);         // reuses the tombstone
      send_request(OP_DELETE, 32'd0);            // no longer present, stops at empty
      send_request(OP_UNUSED, 32'hFFFF_FFFF);    // unknown op
      send_request(OP_UNUSED, 32'd1024);         // unknown op on a held key
      send_request(OP_INSERT, 32'hFFFF_FFFF);    // -1, home 1, collides
      send_request(OP_INSERT, 32'd1);            // +1, same home, next probe
      send_request(OP_DELETE, 32'hFFFF_FFFF);
      send_request(OP_LOOKUP, 32'd1);            // past the tombstone of -1
      send_request(OP_DELETE, 32'h7FFF_FFFF);
      send_request(OP_DELETE, 32'h7FFF_FFFF);    // only tombstones on the orbit
      send_request(OP_INSERT, 32'd1023);         // takes the tombstone
      send_request(OP_LOOKUP, 32'hFFFF_FC01);    // -1023, same home, different key
      send_request(OP_DELETE, 32'd500);          // empty home slot
      drain_responses();

      // random part, three idling phases with a full drain between them
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               tx_idle_pct = 31;
               rx_idle_pct = 46;
            end
            1: begin
               tx_idle_pct = 46;
               rx_idle_pct = 31;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         phase = p;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) op = OP_INSERT;
            else if (pick < 65) op = OP_DELETE;
            else if (pick < 95) op = OP_LOOKUP;
            else op = OP_UNUSED;
            // half the keys come back from recent ones so deletes and lookups hit
            if ($urandom_range(1) == 0) begin
               key = recent_keys[$urandom_range(15)];
            end else begin
               case ($urandom_range(9))
                  0: key = $urandom();
                  1: key = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  default: begin
                     // homes with short orbits fill up and exhaust the probes
                     case ($urandom_range(6))
                        0: home = 32'd0;
                        1: home = 32'd1;
                        2: home = 32'd255;
                        3: home = 32'd511;
                        4: home = 32'd767;
                        5: home = 32'd1023;
                        default: home = $urandom_range(1023);
                     endcase
                     key = home + 32'd1024 * $urandom_range(7);
                     if ($urandom_range(1) == 1) key = 32'd0 - key;
                  end
               endcase
               recent_keys[$urandom_range(15)] = key;
            end
            send_request(op, key);
         end
         drain_responses();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && replies_owed == 0) begin
         $display("open_addressing_hash_set_core test passed");
      end else begin
         $display("open_addressing_hash_set_core test failed");
      end
      $finish;
   end

endmodule

// File: open_addressing_hash_set_core.f
hdl/oahs_pkg.sv
hdl/open_addressing_hash_set.sv
dv/hash_set_checker.sv
dv/open_addressing_hash_set_core_tb.sv
